// ===== rtl/assert_macros.svh =====
//----------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the checker module.
//----------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define AST_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion, active during reset too.
`define AST_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/irpd_pkg.sv =====
//----------------------------------------------------------------------
// irpd_pkg
// Widths, register map, reset values and window compare for the
// pulse-distance IR frame decoder.
//----------------------------------------------------------------------
package irpd_pkg;

  localparam int TICK_W    = 16;
  localparam int WORD_W    = 32;
  localparam int HALF_W    = 16;
  localparam int REG_IDX_W = 3;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_HEADER       = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ZERO         = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ONE          = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_REPEAT       = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PULSE_MARGIN = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_FRAME        = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_MARGIN = 3'd6;

  // Reset values (2 us tick)
  localparam logic [TICK_W-1:0] RST_HEADER       = 16'd6750;
  localparam logic [TICK_W-1:0] RST_ZERO         = 16'd575;
  localparam logic [TICK_W-1:0] RST_ONE          = 16'd1125;
  localparam logic [TICK_W-1:0] RST_REPEAT       = 16'd5550;
  localparam logic [TICK_W-1:0] RST_PULSE_MARGIN = 16'd50;
  localparam logic [TICK_W-1:0] RST_FRAME        = 16'd53875;
  localparam logic [TICK_W-1:0] RST_FRAME_MARGIN = 16'd175;

  // a within [c - m, c + m] with no wrap:
  //   a >= c - m  <=>  a + m >= c
  //   a <= c + m
  function automatic logic in_window(input logic [TICK_W:0]   a,
                                     input logic [TICK_W:0]   c,
                                     input logic [TICK_W-1:0] m);
    logic [TICK_W+1:0] lo_sum;
    logic [TICK_W+1:0] hi_sum;
    lo_sum = {1'b0, a} + {2'b00, m};
    hi_sum = {1'b0, c} + {2'b00, m};
    return (lo_sum >= {1'b0, c}) && ({1'b0, a} <= hi_sum);
  endfunction

endpackage

// ===== rtl/irpd_in_if.sv =====
//----------------------------------------------------------------------
// irpd_in_if
// Capture channel: one interval measurement or overflow event.
//----------------------------------------------------------------------
interface irpd_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [irpd_pkg::TICK_W-1:0] pulse_ticks;

  modport source (output valid, action, pulse_ticks, input ready);
  modport sink   (input valid, action, pulse_ticks, output ready);
endinterface

// ===== rtl/irpd_out_if.sv =====
//----------------------------------------------------------------------
// irpd_out_if
// Decoded frame channel: address/command halves and repeat flag.
//----------------------------------------------------------------------
interface irpd_out_if;
  logic                        valid;
  logic                        ready;
  logic [irpd_pkg::HALF_W-1:0] address;
  logic [irpd_pkg::HALF_W-1:0] command;
  logic                        is_repeat;

  modport source (output valid, address, command, is_repeat, input ready);
  modport sink   (input valid, address, command, is_repeat, output ready);
endinterface

// ===== rtl/ir_pulse_distance_frame_decoder_top.sv =====
//----------------------------------------------------------------------
// ir_pulse_distance_frame_decoder_top
// Pulse-distance IR decoder: header search, DATA_BITS bit intervals
// shifted in LSB first, then gap/repeat pulse tracking.
//----------------------------------------------------------------------
//  channel   dir  payload                          handshake
//  in_ch     in   action, pulse_ticks              valid/ready
//  out_ch    out  address, command, is_repeat      valid/ready
//  cfg       in   cfg_idx, cfg_data                cfg_we, no stall
//
//  One request per cycle sustained while out_ch takes results. An
//  accepted request sits in the capture register and is decoded when the
//  output register is empty or being taken; its result is registered there.
//  The capture register waits only while the output register holds an
//  untaken result. Synchronous reset: decoder idle, registers at defaults.
//----------------------------------------------------------------------
module ir_pulse_distance_frame_decoder_top #(
  parameter int DATA_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  irpd_in_if.sink                        in_ch,
  irpd_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [irpd_pkg::REG_IDX_W-1:0] cfg_idx,
  input  logic [irpd_pkg::TICK_W-1:0]    cfg_data
);

  localparam int BL_W = $clog2(DATA_BITS + 1);
  localparam int TW   = irpd_pkg::TICK_W;
  localparam int WW   = irpd_pkg::WORD_W;
  localparam int HW   = irpd_pkg::HALF_W;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_BIT,
    PH_GAP,
    PH_RPT
  } phase_t;

  // Configuration registers
  logic [TW-1:0] header_ticks, zero_ticks, one_ticks, repeat_ticks;
  logic [TW-1:0] pulse_margin, frame_ticks, gap_margin;

  // Capture register
  logic          cap_valid;
  logic          cap_action;
  logic [TW-1:0] cap_ticks;
  logic          cap_go;

  // Decoder state
  phase_t          phase, phase_next;
  logic [BL_W-1:0] bits_left, bits_left_next;
  logic [WW-1:0]   shift_word, shift_word_next;
  logic [TW-1:0]   message_length, message_length_next;

  logic emit, emit_repeat;
  logic hdr_hit, one_hit, zero_hit, gap_hit, rpt_hit;
  logic [TW:0] gap_sum;

  // Output register
  logic          out_valid;
  logic [HW-1:0] out_address, out_command;
  logic          out_repeat;

  assign cap_go      = cap_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !cap_valid || cap_go;

  assign out_ch.valid     = out_valid;
  assign out_ch.address   = out_address;
  assign out_ch.command   = out_command;
  assign out_ch.is_repeat = out_repeat;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_ticks <= irpd_pkg::RST_HEADER;
      zero_ticks   <= irpd_pkg::RST_ZERO;
      one_ticks    <= irpd_pkg::RST_ONE;
      repeat_ticks <= irpd_pkg::RST_REPEAT;
      pulse_margin <= irpd_pkg::RST_PULSE_MARGIN;
      frame_ticks  <= irpd_pkg::RST_FRAME;
      gap_margin   <= irpd_pkg::RST_FRAME_MARGIN;
    end else if (cfg_we) begin
      case (cfg_idx)
        irpd_pkg::REG_HEADER:       header_ticks <= cfg_data;
        irpd_pkg::REG_ZERO:         zero_ticks   <= cfg_data;
        irpd_pkg::REG_ONE:          one_ticks    <= cfg_data;
        irpd_pkg::REG_REPEAT:       repeat_ticks <= cfg_data;
        irpd_pkg::REG_PULSE_MARGIN: pulse_margin <= cfg_data;
        irpd_pkg::REG_FRAME:        frame_ticks  <= cfg_data;
        irpd_pkg::REG_FRAME_MARGIN: gap_margin   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Window compares; the gap test folds message_length into the pulse side
  assign gap_sum  = {1'b0, cap_ticks} + {1'b0, message_length};
  assign hdr_hit  = irpd_pkg::in_window({1'b0, cap_ticks}, {1'b0, header_ticks}, pulse_margin);
  assign one_hit  = irpd_pkg::in_window({1'b0, cap_ticks}, {1'b0, one_ticks}, pulse_margin);
  assign zero_hit = irpd_pkg::in_window({1'b0, cap_ticks}, {1'b0, zero_ticks}, pulse_margin);
  assign gap_hit  = irpd_pkg::in_window(gap_sum, {1'b0, frame_ticks}, gap_margin);
  assign rpt_hit  = irpd_pkg::in_window({1'b0, cap_ticks}, {1'b0, repeat_ticks}, gap_margin);

  always_comb begin
    phase_next          = phase;
    bits_left_next      = bits_left;
    shift_word_next     = shift_word;
    message_length_next = message_length;
    emit                = 1'b0;
    emit_repeat         = 1'b0;
    if (cap_action) begin
      phase_next = PH_IDLE;
    end else begin
      case (phase)
        PH_IDLE: begin
          phase_next = PH_HEADER;
        end
        PH_BIT: begin
          if (one_hit || zero_hit) begin
            shift_word_next     = {one_hit, shift_word[WW-1:1]};
            bits_left_next      = bits_left - 1'b1;
            message_length_next = message_length + cap_ticks;
            if (bits_left == BL_W'(1)) begin
              phase_next = PH_GAP;
              emit       = 1'b1;
            end
          end else begin
            phase_next = PH_HEADER;
          end
        end
        PH_GAP: begin
          phase_next = gap_hit ? PH_RPT : PH_HEADER;
        end
        PH_RPT: begin
          if (rpt_hit) begin
            phase_next          = PH_GAP;
            emit                = 1'b1;
            emit_repeat         = 1'b1;
            message_length_next = cap_ticks;
          end else begin
            phase_next = PH_HEADER;
          end
        end
        default: begin
          phase_next = PH_HEADER;
          if (hdr_hit) begin
            phase_next          = PH_BIT;
            bits_left_next      = BL_W'(DATA_BITS);
            shift_word_next     = '0;
            message_length_next = cap_ticks;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_valid      <= 1'b0;
      out_valid      <= 1'b0;
      phase          <= PH_IDLE;
      bits_left      <= '0;
      shift_word     <= '0;
      message_length <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        cap_valid  <= 1'b1;
        cap_action <= in_ch.action;
        cap_ticks  <= in_ch.pulse_ticks;
      end else if (cap_go) begin
        cap_valid <= 1'b0;
      end

      if (cap_go) begin
        phase          <= phase_next;
        bits_left      <= bits_left_next;
        shift_word     <= shift_word_next;
        message_length <= message_length_next;
        out_valid      <= emit;
        if (emit) begin
          out_address <= shift_word_next[HW-1:0];
          out_command <= shift_word_next[WW-1:HW];
          out_repeat  <= emit_repeat;
        end
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/irpd_checker.sv =====
//----------------------------------------------------------------------
// irpd_checker
// Port-level checks on the decoder's channels, bound to the top level.
//----------------------------------------------------------------------
`include "assert_macros.svh"

module irpd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [irpd_pkg::HALF_W-1:0] address,
  input logic [irpd_pkg::HALF_W-1:0] command,
  input logic                        is_repeat
);

  `AST_RST(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `AST_RST(a_out_stable, clk, rst, out_valid && !out_ready |=> $stable(address) && $stable(command) && $stable(is_repeat), "stalled result changed")
  `AST_ALL(a_rst_clear, clk, rst |=> !out_valid, "result valid right after reset")
  `AST_RST(a_ready_when_free, clk, rst, !out_valid |-> in_ready, "input stalled with empty output")
  `AST_RST(a_cap_full, clk, rst, out_valid && !out_ready && $past(out_valid && !out_ready && in_valid && in_ready) |-> !in_ready, "capture overrun while output stalled")

endmodule

bind ir_pulse_distance_frame_decoder_top irpd_checker u_irpd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .address   (out_ch.address),
  .command   (out_ch.command),
  .is_repeat (out_ch.is_repeat)
);
